// ===== hw/rtl/i2crm_pkg.sv =====
// Package for the I2C register master: phase codes, operation and status codes,
// and the request/response payload structs. No dependencies.
package i2crm_pkg;

   localparam logic [15:0] STRETCH_LIMIT_RESET  = 16'd200;
   localparam logic [7:0]  ACK_WAIT_LIMIT_RESET = 8'd5;
   localparam int unsigned QUEUE_DEPTH          = 2;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_NACK    = 3'd1;
   localparam logic [2:0] STATUS_TIMEOUT = 3'd2;
   localparam logic [2:0] STATUS_STUCK   = 3'd3;
   localparam logic [2:0] STATUS_BAD_REQ = 3'd4;

   localparam logic csr_index_stretch  = 1'b0;
   localparam logic csr_index_ack_wait = 1'b1;

   typedef enum logic [4:0] {
      PH_IDLE, PH_START0, PH_START1, PH_START2, PH_START3, PH_LOAD,
      PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH, PH_TX_END, PH_ACK_REL, PH_ACK_SCL,
      PH_ACK_SDA, PH_ACK_FAIL, PH_AFTER_ACK, PH_RX_BEGIN, PH_RX_LOW, PH_RX_REL,
      PH_RX_SCL, PH_RX_SAMPLE, PH_RA1, PH_RA2, PH_NA1, PH_NA2, PH_SP0, PH_SP1,
      PH_SP2, PH_SP3, PH_TAIL, PH_FIN
   } phase_type;

   typedef enum logic [1:0] {
      BY_ADDRW, BY_REG, BY_ADDRR, BY_WDATA
   } byte_stage_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] length;
      logic [7:0] tx_byte;
      logic       scl_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       tx_taken;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

endpackage

// ===== hw/rtl/i2crm_req_if.sv =====
// Valid/ready channel interfaces for the I2C register master.
// Depends on i2crm_pkg for the payload structs.
interface i2crm_req_if;
   logic              valid;
   logic              ready;
   i2crm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface i2crm_rsp_if;
   logic              valid;
   logic              ready;
   i2crm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/i2crm_front.sv =====
// Front end: accepts request beats into a small queue so the engine can stall
// independently of the requester. Depends on i2crm_pkg.
module i2crm_front #(
   parameter int unsigned Depth = i2crm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  i2crm_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output i2crm_pkg::req_type out_data
);
   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   i2crm_pkg::req_type     slot_ff [Depth];
   logic [PtrW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]          count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != (PtrW+1)'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(Depth))
      else $error("request queue overflow");
   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("request queue count slip on pop");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("request queue count slip on push");
endmodule

// ===== hw/rtl/i2crm_engine.sv =====
// Back end: the I2C bus sequencer. Advances one phase chain per tick beat and
// registers the response beat. Depends on i2crm_pkg.
module i2crm_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        stretch_limit,
   input  logic [7:0]         ack_wait_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  i2crm_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output i2crm_pkg::rsp_type out_data
);
   i2crm_pkg::phase_type      phase_ff, phase_in;
   logic [2:0]                ticks_ff, ticks_in;
   logic [3:0]                bit_ff, bit_in;
   logic [7:0]                shift_ff, shift_in;
   logic [7:0]                left_ff, left_in;
   logic [6:0]                dev_ff, dev_in;
   logic [7:0]                reg_ff, reg_in;
   logic                      read_ff, read_in;
   logic [15:0]               wait_ff, wait_in;
   logic [2:0]                fstat_ff, fstat_in;
   i2crm_pkg::byte_stage_type stage_ff, stage_in;
   logic                      scl_ff, scl_in_n, sda_ff, sda_in_n, listen_ff, listen_in;
   logic                      rsp_valid_ff;
   i2crm_pkg::rsp_type        rsp_ff, rsp_in;
   logic                      take;
   logic                      run;
   logic [15:0]               wait_inc;

   assign in_ready  = !rsp_valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   // Phase chain: up to eight zero-delay steps are walked in one tick.
   always_comb begin
      phase_in  = phase_ff;  ticks_in = ticks_ff;  bit_in = bit_ff;
      shift_in  = shift_ff;  left_in  = left_ff;   dev_in = dev_ff;
      reg_in    = reg_ff;    read_in  = read_ff;   wait_in = wait_ff;
      fstat_in  = fstat_ff;  stage_in = stage_ff;
      scl_in_n  = scl_ff;    sda_in_n = sda_ff;    listen_in = listen_ff;
      rsp_in    = '0;
      run       = 1'b0;
      wait_inc  = '0;
      if (phase_ff == i2crm_pkg::PH_IDLE) begin
         if (in_data.operation == i2crm_pkg::OP_WRITE ||
             in_data.operation == i2crm_pkg::OP_READ) begin
            dev_in   = in_data.dev_addr;
            reg_in   = in_data.reg_addr;
            left_in  = in_data.length;
            read_in  = (in_data.operation == i2crm_pkg::OP_READ);
            fstat_in = i2crm_pkg::STATUS_OK;
            stage_in = i2crm_pkg::BY_ADDRW;
            if (read_in && left_in == 8'd0) begin
               fstat_in        = i2crm_pkg::STATUS_BAD_REQ;
               rsp_in.done_res = 1'b1;
               rsp_in.status   = i2crm_pkg::STATUS_BAD_REQ;
            end else begin
               phase_in = i2crm_pkg::PH_START0;
               ticks_in = '0;
               run      = 1'b1;
            end
         end
      end else begin
         rsp_in.busy_res = 1'b1;
         if (ticks_ff != '0) begin
            ticks_in = ticks_ff - 1'b1;
         end else begin
            run = 1'b1;
         end
      end
      for (int s = 0; s < 8; s++) begin
         if (run) begin
            run = 1'b0;
            case (phase_in)
               i2crm_pkg::PH_START0: begin
                  sda_in_n = 1'b1; phase_in = i2crm_pkg::PH_START1; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_START1: begin
                  scl_in_n = 1'b1; phase_in = i2crm_pkg::PH_START2; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_START2: begin
                  sda_in_n = 1'b0; phase_in = i2crm_pkg::PH_START3; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_START3: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_LOAD; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_LOAD: begin
                  case (stage_in)
                     i2crm_pkg::BY_ADDRW: shift_in = {dev_in, 1'b0};
                     i2crm_pkg::BY_REG:   shift_in = reg_in;
                     i2crm_pkg::BY_ADDRR: shift_in = {dev_in, 1'b1};
                     default: begin
                        shift_in        = in_data.tx_byte;
                        rsp_in.tx_taken = 1'b1;
                     end
                  endcase
                  bit_in   = '0;
                  phase_in = i2crm_pkg::PH_TX_LOW;
                  run      = 1'b1;
               end
               i2crm_pkg::PH_TX_LOW: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_TX_DATA; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_TX_DATA: begin
                  sda_in_n = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
                  phase_in = i2crm_pkg::PH_TX_HIGH; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_TX_HIGH: begin
                  scl_in_n = 1'b1;
                  bit_in   = bit_in + 1'b1;
                  phase_in = (bit_in >= 4'd8) ? i2crm_pkg::PH_TX_END
                                              : i2crm_pkg::PH_TX_LOW;
                  ticks_in = 3'd0;
               end
               i2crm_pkg::PH_TX_END: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_ACK_REL; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_ACK_REL: begin
                  listen_in = 1'b1; scl_in_n = 1'b1; wait_in = '0;
                  phase_in  = i2crm_pkg::PH_ACK_SCL; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_ACK_SCL: begin
                  if (in_data.scl_in) begin
                     wait_in  = '0;
                     phase_in = i2crm_pkg::PH_ACK_SDA;
                     run      = 1'b1;
                  end else begin
                     wait_inc = wait_in + 1'b1;
                     wait_in  = wait_inc;
                     if (wait_inc == stretch_limit) begin
                        fstat_in  = i2crm_pkg::STATUS_TIMEOUT;
                        listen_in = 1'b0;
                        phase_in  = i2crm_pkg::PH_SP0;
                        run       = 1'b1;
                     end else begin
                        ticks_in = 3'd0;
                     end
                  end
               end
               i2crm_pkg::PH_ACK_SDA: begin
                  if (!in_data.sda_in) begin
                     listen_in = 1'b0; scl_in_n = 1'b0;
                     phase_in  = i2crm_pkg::PH_AFTER_ACK; ticks_in = 3'd1;
                  end else begin
                     wait_inc = wait_in + 1'b1;
                     wait_in  = wait_inc;
                     phase_in = (wait_inc == {8'd0, ack_wait_limit}) ?
                                i2crm_pkg::PH_ACK_FAIL : i2crm_pkg::PH_ACK_SDA;
                     ticks_in = 3'd0;
                  end
               end
               i2crm_pkg::PH_ACK_FAIL: begin
                  fstat_in = i2crm_pkg::STATUS_NACK; listen_in = 1'b0;
                  phase_in = i2crm_pkg::PH_SP0; run = 1'b1;
               end
               i2crm_pkg::PH_AFTER_ACK: begin
                  case (stage_in)
                     i2crm_pkg::BY_ADDRW: begin
                        stage_in = i2crm_pkg::BY_REG; phase_in = i2crm_pkg::PH_LOAD;
                     end
                     i2crm_pkg::BY_REG: begin
                        if (read_in) begin
                           stage_in = i2crm_pkg::BY_ADDRR;
                           phase_in = i2crm_pkg::PH_START0;
                        end else if (left_in != 8'd0) begin
                           stage_in = i2crm_pkg::BY_WDATA;
                           phase_in = i2crm_pkg::PH_LOAD;
                        end else begin
                           phase_in = i2crm_pkg::PH_SP0;
                        end
                     end
                     i2crm_pkg::BY_ADDRR: phase_in = i2crm_pkg::PH_RX_BEGIN;
                     default: begin
                        left_in  = left_in - 1'b1;
                        phase_in = (left_in != 8'd0) ? i2crm_pkg::PH_LOAD
                                                     : i2crm_pkg::PH_SP0;
                     end
                  endcase
                  run = 1'b1;
               end
               i2crm_pkg::PH_RX_BEGIN: begin
                  listen_in = 1'b1; bit_in = '0; shift_in = '0;
                  phase_in  = i2crm_pkg::PH_RX_LOW; run = 1'b1;
               end
               i2crm_pkg::PH_RX_LOW: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_RX_REL; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_RX_REL: begin
                  scl_in_n = 1'b1; wait_in = '0;
                  phase_in = i2crm_pkg::PH_RX_SCL; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_RX_SCL: begin
                  if (in_data.scl_in) begin
                     phase_in = i2crm_pkg::PH_RX_SAMPLE; ticks_in = 3'd0;
                  end else begin
                     wait_inc = wait_in + 1'b1;
                     wait_in  = wait_inc;
                     if (wait_inc == stretch_limit) begin
                        scl_in_n = 1'b0; listen_in = 1'b0;
                        fstat_in = i2crm_pkg::STATUS_TIMEOUT;
                        phase_in = i2crm_pkg::PH_SP0; run = 1'b1;
                     end else begin
                        ticks_in = 3'd0;
                     end
                  end
               end
               i2crm_pkg::PH_RX_SAMPLE: begin
                  shift_in = {shift_in[6:0], in_data.sda_in};
                  bit_in   = bit_in + 1'b1;
                  if (bit_in < 4'd8) begin
                     phase_in = i2crm_pkg::PH_RX_LOW; run = 1'b1;
                  end else begin
                     scl_in_n        = 1'b0;
                     listen_in       = 1'b0;
                     rsp_in.rx_valid = 1'b1;
                     rsp_in.rx_byte  = shift_in;
                     left_in         = left_in - 1'b1;
                     ticks_in        = 3'd0;
                     if (left_in != 8'd0) begin
                        sda_in_n = 1'b0; phase_in = i2crm_pkg::PH_RA1;
                     end else begin
                        sda_in_n = 1'b1; phase_in = i2crm_pkg::PH_NA1;
                     end
                  end
               end
               i2crm_pkg::PH_RA1: begin
                  scl_in_n = 1'b1; phase_in = i2crm_pkg::PH_RA2; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_RA2: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_RX_BEGIN; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_NA1: begin
                  scl_in_n = 1'b1; phase_in = i2crm_pkg::PH_NA2; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_NA2: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_SP0; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_SP0: begin
                  scl_in_n = 1'b0; phase_in = i2crm_pkg::PH_SP1; ticks_in = 3'd1;
               end
               i2crm_pkg::PH_SP1: begin
                  sda_in_n = 1'b0; phase_in = i2crm_pkg::PH_SP2; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_SP2: begin
                  scl_in_n = 1'b1; phase_in = i2crm_pkg::PH_SP3; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_SP3: begin
                  sda_in_n = 1'b1; phase_in = i2crm_pkg::PH_TAIL; ticks_in = 3'd0;
               end
               i2crm_pkg::PH_TAIL: begin
                  if (fstat_in != i2crm_pkg::STATUS_OK) begin
                     phase_in        = i2crm_pkg::PH_IDLE;
                     rsp_in.done_res = 1'b1;
                     rsp_in.status   = fstat_in;
                  end else begin
                     phase_in = i2crm_pkg::PH_FIN; ticks_in = 3'd0;
                  end
               end
               i2crm_pkg::PH_FIN: begin
                  if (read_in && (!in_data.sda_in || !in_data.scl_in)) begin
                     fstat_in = i2crm_pkg::STATUS_STUCK;
                  end
                  phase_in        = i2crm_pkg::PH_IDLE;
                  rsp_in.done_res = 1'b1;
                  rsp_in.status   = fstat_in;
               end
               default: begin
                  phase_in = i2crm_pkg::PH_IDLE; ticks_in = '0;
               end
            endcase
         end
      end
      rsp_in.scl_release = scl_in_n;
      rsp_in.sda_release = listen_in | sda_in_n;
   end

   // Sequencer state, advanced once per accepted tick beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2crm_pkg::PH_IDLE;  ticks_ff <= '0;  bit_ff <= '0;
         shift_ff <= '0;  left_ff <= '0;  dev_ff <= '0;  reg_ff <= '0;
         read_ff  <= 1'b0; wait_ff <= '0; fstat_ff <= '0;
         stage_ff <= i2crm_pkg::BY_ADDRW;
         scl_ff <= 1'b1; sda_ff <= 1'b1; listen_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;  ticks_ff <= ticks_in;  bit_ff <= bit_in;
         shift_ff <= shift_in;  left_ff <= left_in;  dev_ff <= dev_in;
         reg_ff   <= reg_in;    read_ff <= read_in;  wait_ff <= wait_in;
         fstat_ff <= fstat_in;  stage_ff <= stage_in;
         scl_ff <= scl_in_n; sda_ff <= sda_in_n; listen_ff <= listen_in;
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_in.done_res) |=> (phase_ff == i2crm_pkg::PH_IDLE))
      else $error("done reported without returning to idle");
   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.done_res) |-> (rsp_ff.status == i2crm_pkg::STATUS_OK))
      else $error("status set without done");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response changed");
endmodule

// ===== hw/rtl/i2c_register_master_unit.sv =====
// Top level of the I2C register master: configuration registers, request queue
// and bus sequencer. Depends on i2crm_pkg, the channel interfaces, front, engine.
//
//   channel | direction | payload
//   req     | in        | operation, dev_addr, reg_addr, length, tx_byte, scl_in, sda_in
//   rsp     | out       | scl_release, sda_release, tx_taken, rx_byte, rx_valid,
//           |           | busy_res, done_res, status
//   csr     | in        | write enable, register index, 16-bit data
//
// One request beat produces one response beat; a beat is taken every cycle while
// the response side is ready. A request passes through the queue and then the
// response register; the sequencer steps one bus tick per beat.
// Reset is synchronous and leaves both bus lines released and the sequencer idle.
// A stalled response side fills the two-entry queue before the request side stalls.
module i2c_register_master_unit #(
   parameter int unsigned QueueDepth = i2crm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   i2crm_req_if.sink   req,
   i2crm_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   logic [15:0]        stretch_limit_ff;
   logic [7:0]         ack_wait_limit_ff;
   logic               q_valid, q_ready;
   i2crm_pkg::req_type q_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stretch_limit_ff  <= i2crm_pkg::STRETCH_LIMIT_RESET;
         ack_wait_limit_ff <= i2crm_pkg::ACK_WAIT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == i2crm_pkg::csr_index_stretch) begin
            stretch_limit_ff <= csr_write_data;
         end else begin
            ack_wait_limit_ff <= csr_write_data[7:0];
         end
      end
   end

   i2crm_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_data (req.data),
      .out_valid(q_valid),   .out_ready(q_ready),   .out_data(q_data)
   );

   i2crm_engine u_engine (
      .clock, .reset,
      .stretch_limit (stretch_limit_ff),
      .ack_wait_limit(ack_wait_limit_ff),
      .in_valid (q_valid),   .in_ready (q_ready),   .in_data (q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule
